>>> rtl/core/miller_rabin_round_defines.svh
// Assertion macros for the Miller-Rabin round block.
`ifndef MILLER_RABIN_ROUND_DEFINES_SVH
`define MILLER_RABIN_ROUND_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define MR_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define MR_ASSERT(label, clk, rst_n, prop)
`define MR_NEVER(label, clk, rst_n, cond)
`endif
`endif

>>> rtl/core/mr_pkg.sv
// Package for the Miller-Rabin round block: widths and shared types.
package mr_pkg;
    localparam int NUM_WIDTH = 32;
    localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);
    typedef logic [NUM_WIDTH-1:0] num_t;
    typedef logic [CNT_WIDTH-1:0] cnt_t;
endpackage

>>> rtl/core/miller_rabin_round.sv
// Top level of the Miller-Rabin round block.
// One item holds a candidate n and a witness a, and gives one verdict item.
// Candidates 0 to 4 and even candidates go straight to the output. For odd
// n above 4 the witness is first reduced modulo n by shift-and-subtract with
// its own comparator; then a single shared modular add/compare unit does
// every modular multiplication as a shift-and-add over the bits of the
// multiplier, with the modular add of a set bit and the doubling of the
// multiplicand done as separate steps. The exponentiation needs a squaring
// for every exponent bit and a further multiplication for every set bit,
// and the squaring phase up to s-1 more squarings. The input is not ready
// while an item is at work; the verdict waits in an output register until
// taken, and the next item is accepted in the same cycle as the verdict
// leaves.
`include "miller_rabin_round_defines.svh"
module miller_rabin_round (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // candidate [31:0], witness [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata   // probably_prime [0], witness_invalid [1], zeros above
);
    localparam int W = mr_pkg::NUM_WIDTH;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RED, ST_DEC, ST_PBIT, ST_MUL, ST_PSQ, ST_CHK, ST_SQ, ST_SQCHK,
        ST_OUT
    } state_t;
    typedef enum logic [1:0] {RET_PMUL, RET_PSQ, RET_SQ} ret_t;

    state_t       state_reg;
    ret_t         ret_reg;
    mr_pkg::num_t n_reg, b_reg, e_reg, acc_reg, x_reg, y_reg, p_reg, r_reg;
    mr_pkg::num_t a_reg;
    mr_pkg::cnt_t s_reg, i_reg;
    logic         prime_reg, bad_reg, out_valid_reg;

    // Shared unit: (u + v) mod n for u, v < n, with a (W+1)-bit sum.
    mr_pkg::num_t    u, v, addm;
    logic [W:0]      sum, diff;
    mr_pkg::num_t    nm1;
    mr_pkg::num_t    cand, wit;
    logic [W:0]      rsh;

    assign cand = s_tdata[W-1:0];
    assign wit  = s_tdata[2*W-1:W];
    assign nm1  = n_reg - mr_pkg::num_t'(1);
    assign sum  = {1'b0, u} + {1'b0, v};
    assign diff = sum - {1'b0, n_reg};
    assign addm = diff[W] ? sum[W-1:0] : diff[W-1:0];
    assign rsh  = {r_reg, a_reg[W-1]};

    always_comb
    begin
        u = p_reg;
        v = p_reg;
        if (state_reg == ST_MUL && y_reg[0])
        begin
            u = r_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, bad_reg, prime_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            ret_reg       <= RET_PMUL;
            prime_reg     <= 1'b0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_OUT && (!out_valid_reg || m_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tvalid && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        n_reg     <= cand;
                        a_reg     <= wit;
                        r_reg     <= '0;
                        i_reg     <= '0;
                        if (cand <= mr_pkg::num_t'(4))
                        begin
                            prime_reg <= (cand == mr_pkg::num_t'(2)) ||
                                         (cand == mr_pkg::num_t'(3));
                            bad_reg   <= 1'b0;
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            prime_reg <= 1'b0;
                            bad_reg <= (wit < mr_pkg::num_t'(2)) ||
                                       (wit > cand - mr_pkg::num_t'(2));
                            state_reg <= cand[0] ? ST_RED : ST_OUT;
                        end
                    end
                end
                ST_RED:
                begin
                    // Restoring reduction of the witness modulo n, one bit a cycle.
                    if (rsh >= {1'b0, n_reg})
                    begin
                        r_reg <= mr_pkg::num_t'(rsh - {1'b0, n_reg});
                    end
                    else
                    begin
                        r_reg <= rsh[W-1:0];
                    end
                    a_reg <= {a_reg[W-2:0], 1'b0};
                    i_reg <= i_reg + mr_pkg::cnt_t'(1);
                    if (i_reg == mr_pkg::cnt_t'(W - 1))
                    begin
                        e_reg     <= nm1 >> 1;
                        s_reg     <= mr_pkg::cnt_t'(1);
                        state_reg <= ST_DEC;
                    end
                end
                ST_DEC:
                begin
                    // Strip trailing zeros of n-1; b holds a mod n.
                    b_reg <= r_reg;
                    if (!e_reg[0])
                    begin
                        e_reg <= e_reg >> 1;
                        s_reg <= s_reg + mr_pkg::cnt_t'(1);
                    end
                    else
                    begin
                        acc_reg   <= mr_pkg::num_t'(1);
                        state_reg <= ST_PBIT;
                    end
                end
                ST_PBIT:
                begin
                    if (e_reg == '0)
                    begin
                        x_reg     <= acc_reg;
                        state_reg <= ST_CHK;
                    end
                    else if (e_reg[0])
                    begin
                        r_reg <= '0; p_reg <= b_reg; y_reg <= acc_reg;
                        ret_reg <= RET_PMUL; state_reg <= ST_MUL;
                    end
                    else
                    begin
                        state_reg <= ST_PSQ;
                    end
                end
                ST_PSQ:
                begin
                    r_reg <= '0; p_reg <= b_reg; y_reg <= b_reg;
                    ret_reg <= RET_PSQ; state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    // r accumulates p*y mod n; one modular add a cycle.
                    if (y_reg == '0)
                    begin
                        case (ret_reg)
                            RET_PMUL:
                            begin
                                acc_reg   <= r_reg;
                                state_reg <= ST_PSQ;
                            end
                            RET_PSQ:
                            begin
                                b_reg     <= r_reg;
                                e_reg     <= e_reg >> 1;
                                state_reg <= ST_PBIT;
                            end
                            default:
                            begin
                                x_reg     <= r_reg;
                                state_reg <= ST_SQCHK;
                            end
                        endcase
                    end
                    else if (y_reg[0])
                    begin
                        r_reg <= addm;
                        y_reg <= y_reg & ~mr_pkg::num_t'(1);
                    end
                    else
                    begin
                        p_reg <= addm;
                        y_reg <= y_reg >> 1;
                    end
                end
                ST_CHK:
                begin
                    i_reg <= mr_pkg::cnt_t'(1);
                    if (x_reg == mr_pkg::num_t'(1) || x_reg == nm1)
                    begin
                        prime_reg <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ:
                begin
                    if (i_reg >= s_reg)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        r_reg <= '0; p_reg <= x_reg; y_reg <= x_reg;
                        ret_reg <= RET_SQ; state_reg <= ST_MUL;
                    end
                end
                ST_SQCHK:
                begin
                    i_reg <= i_reg + mr_pkg::cnt_t'(1);
                    if (x_reg == nm1)
                    begin
                        prime_reg <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                    else if (x_reg == mr_pkg::num_t'(1))
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_SQ;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `MR_NEVER(a_busy_not_ready, clk, rst_n, (state_reg != ST_IDLE) && s_tready)
    `MR_ASSERT(a_acc_below_n, clk, rst_n,
        (state_reg == ST_MUL) |-> (r_reg < n_reg && p_reg < n_reg))
    `MR_ASSERT(a_small_no_flag, clk, rst_n, (m_tvalid && n_reg <= mr_pkg::num_t'(4)) |-> !bad_reg)
endmodule

>>> sim/testbench.sv
// Self-checking testbench for the Miller-Rabin round block.
`timescale 1ns / 100ps
module testbench;

    localparam int MAX_CYCLES = 10000000;

    typedef struct packed {
        logic prime;
        logic bad_base;
    } verdict_t;

    typedef struct {
        mr_pkg::num_t cand;
        mr_pkg::num_t base;
        logic chk;      // typed-in expectation present
        logic prime;
        logic bad_base;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // candidate [31:0], witness [63:32]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // probably_prime [0], witness_invalid [1]

    verdict_t verdicts_due[$];
    int       errors = 0;
    int       cycles = 0;
    int       verdicts_seen = 0;
    int       primes_seen = 0;
    int       bad_bases_seen = 0;

    miller_rabin_round dut (.*);

    always #4 clk = ~clk;

    // Modular product from the full double-width product.
    function automatic mr_pkg::num_t mod_mul(mr_pkg::num_t x, mr_pkg::num_t y,
                                             mr_pkg::num_t m);
        logic [63:0] prod;
        prod = 64'(x) * 64'(y);
        return mr_pkg::num_t'(prod % 64'(m));
    endfunction

    function automatic verdict_t mr_verdict(mr_pkg::num_t n, mr_pkg::num_t a);
        verdict_t     v;
        mr_pkg::num_t d, x, nm1;
        int           s;
        v = '0;
        if (n <= 4)
        begin
            v.prime = (n == 2 || n == 3);
            return v;
        end
        nm1 = n - 1;
        v.bad_base = (a < 2 || a > n - 2);
        if (!n[0])
            return v;
        d = nm1;
        s = 0;
        while (!d[0])
        begin
            d = d >> 1;
            s++;
        end
        // Square-and-multiply on the reduced base.
        x = 1;
        begin
            mr_pkg::num_t b, e;
            b = a % n;
            e = d;
            while (e != 0)
            begin
                if (e[0])
                    x = mod_mul(x, b, n);
                b = mod_mul(b, b, n);
                e = e >> 1;
            end
        end
        if (x == 1 || x == nm1)
        begin
            v.prime = 1'b1;
            return v;
        end
        for (int i = 1; i < s; i++)
        begin
            x = mod_mul(x, x, n);
            if (x == nm1)
            begin
                v.prime = 1'b1;
                break;
            end
            if (x == 1)
                break;
        end
        return v;
    endfunction

    // Receiver: stalls in a repeating pattern with random stretches.
    initial
    begin
        int phase;
        phase = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            phase++;
            m_tready <= (phase % 64 < 40) ? 1'b1 : ((phase % 7 != 0) && $urandom_range(0, 1));
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        verdict_t want, got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.prime = m_tdata[0];
            got.bad_base = m_tdata[1];
            verdicts_seen++;
            primes_seen += got.prime;
            bad_bases_seen += got.bad_base;
            if (verdicts_due.size() == 0)
            begin
                $error("verdict item with none expected");
                errors++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (got.prime !== want.prime)
                begin
                    $error("probably_prime expected %0b got %0b", want.prime, got.prime);
                    errors++;
                end
                if (got.bad_base !== want.bad_base)
                begin
                    $error("witness_invalid expected %0b got %0b",
                           want.bad_base, got.bad_base);
                    errors++;
                end
                if (m_tdata[7:2] !== '0)
                begin
                    $error("padding expected 0 got %0h", m_tdata[7:2]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLES)
        begin
            $display("miller_rabin_round verification failed");
            $finish;
        end
    end

    int burst_left = 0;

    // Sends one item, honouring the burst-and-gap pattern of the sender.
    task automatic send_candidate(mr_pkg::num_t n, mr_pkg::num_t a, verdict_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {a, n};
        do @(posedge clk); while (!s_tready);
        verdicts_due.push_back(want);
        burst_left--;
    endtask

    // Picks a random odd candidate: random or small values, products, or two fixed cases.
    function automatic mr_pkg::num_t random_candidate();
        mr_pkg::num_t n;
        case ($urandom_range(0, 5))
            0: n = $urandom();
            1: n = $urandom_range(5, 1000);
            2: n = mr_pkg::num_t'($urandom_range(3, 65535)) *
                   mr_pkg::num_t'($urandom_range(3, 65535));
            3: n = 32'hFFFF_FFFB;                 // largest 32-bit prime
            4: n = 32'd3215031751;                // strong pseudoprime to 2, 3, 5, 7
            default: n = $urandom() | 32'h8000_0001;
        endcase
        return n | 32'd1;
    endfunction

    row_t directed[] = '{
        '{32'd0, 32'd7, 1'b1, 1'b0, 1'b0},
        '{32'd1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0},
        '{32'd2, 32'd0, 1'b1, 1'b1, 1'b0},
        '{32'd3, 32'd2, 1'b1, 1'b1, 1'b0},
        '{32'd4, 32'd3, 1'b1, 1'b0, 1'b0},
        '{32'd6, 32'd2, 1'b1, 1'b0, 1'b0},
        '{32'd6, 32'd9, 1'b1, 1'b0, 1'b1},
        '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1},
        '{32'd5, 32'd2, 1'b1, 1'b1, 1'b0},
        '{32'd7, 32'd1, 1'b1, 1'b1, 1'b1},   // witness of one always passes
        '{32'd7, 32'd6, 1'b1, 1'b1, 1'b1},   // witness of n-1 always passes
        '{32'd7, 32'd0, 1'b1, 1'b0, 1'b1},   // witness of zero always fails
        '{32'd7, 32'd14, 1'b1, 1'b0, 1'b1},  // multiple of the candidate
        '{32'd9, 32'd2, 1'b0, 1'b0, 1'b0},
        '{32'd2047, 32'd2, 1'b0, 1'b0, 1'b0},      // strong pseudoprime to base two
        '{32'd561, 32'd2, 1'b0, 1'b0, 1'b0},
        '{32'hFFFF_FFFB, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0},
        '{32'hFFFF_FFFB, 32'hFFFF_FFF9, 1'b0, 1'b0, 1'b0},
        '{32'hFFFF_FFFB, 32'hFFFF_FFFA, 1'b0, 1'b0, 1'b0},
        '{32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0},
        '{32'hFFFF_FFFF, 32'h5555_5555, 1'b0, 1'b0, 1'b0},
        '{32'h8000_0001, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
        '{32'd3215031751, 32'd7, 1'b0, 1'b0, 1'b0}
    };

    initial
    begin
        verdict_t     want;
        mr_pkg::num_t n, a;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            want = mr_verdict(directed[i].cand, directed[i].base);
            if (directed[i].chk)
            begin
                want.prime = directed[i].prime;
                want.bad_base = directed[i].bad_base;
            end
            send_candidate(directed[i].cand, directed[i].base, want);
        end

        for (int i = 0; i < 270; i++)
        begin
            n = random_candidate();
            // Mostly valid witnesses; the rest anywhere in the field.
            if (n > 32'd4 && $urandom_range(0, 9) < 8)
                a = 2 + ($urandom() % (n - 3));
            else
                a = $urandom();
            if ($urandom_range(0, 19) == 0)
                n = $urandom_range(0, 4) + ($urandom_range(0, 1) ? 0 : 32'd100);
            send_candidate(n, a, mr_verdict(n, a));
        end
        s_tvalid <= 1'b0;

        wait (verdicts_due.size() == 0);
        repeat (100) @(posedge clk);
        $display("Checked %0d verdict items: %0d probably prime, %0d with witness flagged.",
                 verdicts_seen, primes_seen, bad_bases_seen);
        if (errors == 0)
            $display("miller_rabin_round verification clean");
        else
            $display("miller_rabin_round verification failed");
        $finish;
    end
endmodule
